// File: design/quicksort_sorter_defines.svh
// Assertion macros shared by the quicksort sorter RTL.
// Needs signals named clock and reset in the including module.
`ifndef QUICKSORT_SORTER_DEFINES_SVH
`define QUICKSORT_SORTER_DEFINES_SVH

// check prop at every rising clock edge outside reset
`define QS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that expr holds in the cycle after cond
`define QS_ASSERT_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: design/qsort_pkg.sv
// Shared constants, range type and sequencer states of the quicksort sorter.
// No dependencies.
`timescale 1ns / 1ps

package qsort_pkg;

   localparam int MAX_ITEMS   = 32;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int STACK_DEPTH = IDX_W + 2;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SP_IDX_W    = $clog2(STACK_DEPTH);

   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } range_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_POP,
      ST_PIVOT,
      ST_I_RD,
      ST_I_CHK,
      ST_J_CHK,
      ST_SWAP1,
      ST_SWAP2,
      ST_FIN1,
      ST_FIN2,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

endpackage

// File: design/qsort_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module qsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/quicksort_sorter.sv
// Quicksort sorter top level; uses qsort_pkg, qsort_ram and the assertion macros.
// Load: one word per handshake in ST_LOAD. Sort: ST_POP and ST_PIVOT per range,
// the ST_I_CHK/ST_J_CHK scans, ST_SWAP1, ST_SWAP2 and ST_I_RD per swap, and
// ST_FIN1/ST_FIN2 to place the pivot. Output: ST_OUT_RD and ST_OUT_WAIT per word,
// held while the sink is not ready; the next set loads while the final result waits.
// Sync reset clears counters, stack pointer, flag and sequencer, not store or stack.
`timescale 1ns / 1ps
`include "quicksort_sorter_defines.svh"

module quicksort_sorter
   import qsort_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // value[31:0]
   input  logic              req_tlast,   // is_last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // sorted_value[31:0]
   output logic              rsp_tlast,   // last_out
   output logic              rsp_tuser    // overflow
);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   range_type          stack_ff [STACK_DEPTH];
   logic [IDX_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in, k_ff, k_in;
   logic [COUNT_W-1:0] j_ff, j_in;
   logic [DATA_W-1:0]  pivot_ff, pivot_in, vi_ff, vi_in, vj_ff, vj_in;

   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in, rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [DATA_W-1:0]  ram_wdata, ram_rdata;

   logic               push0_en, push1_en;
   logic [SP_IDX_W-1:0] push0_slot, push1_slot;
   range_type          push0_val, push1_val;

   logic signed [DATA_W-1:0] cmp_a, cmp_b;
   logic               cmp_lt;

   logic               req_accept, rsp_accept, store_full;
   logic [COUNT_W-1:0] count_new, j_dec;
   logic [SP_W-1:0]    top_idx;
   range_type          top_range, left_range, right_range;
   logic               left_ok, right_ok, left_larger;
   logic [IDX_W-1:0]   p_idx;

   qsort_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign store_full = (count_ff >= COUNT_W'(MAX_ITEMS));
   assign count_new  = store_full ? count_ff : count_ff + COUNT_W'(1);
   assign j_dec      = j_ff - COUNT_W'(1);
   assign top_idx    = sp_ff - SP_W'(1);
   assign top_range  = stack_ff[top_idx[SP_IDX_W-1:0]];

   // shared signed compare
   assign cmp_a  = (state_ff == ST_I_CHK) ? ram_rdata : pivot_ff;
   assign cmp_b  = (state_ff == ST_I_CHK) ? pivot_ff : ram_rdata;
   assign cmp_lt = (cmp_a < cmp_b);

   assign p_idx       = j_ff[IDX_W-1:0];
   assign left_range  = '{lo: lo_ff, hi: p_idx - IDX_W'(1)};
   assign right_range = '{lo: p_idx + IDX_W'(1), hi: hi_ff};
   assign left_ok     = (COUNT_W'(p_idx) > COUNT_W'(lo_ff) + COUNT_W'(1));
   assign right_ok    = (COUNT_W'(p_idx) + COUNT_W'(1) < COUNT_W'(hi_ff));
   assign left_larger = ((p_idx - lo_ff) > (hi_ff - p_idx));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      sp_in        = sp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      vi_in        = vi_ff;
      vj_in        = vj_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = k_ff;
      push0_en     = 1'b0;
      push1_en     = 1'b0;
      push0_slot   = sp_ff[SP_IDX_W-1:0];
      push1_slot   = SP_IDX_W'(sp_ff + SP_W'(1));
      push0_val    = left_range;
      push1_val    = right_range;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_accept) begin
               ram_we     = !store_full;
               ram_waddr  = count_ff[IDX_W-1:0];
               ram_wdata  = req_tdata;
               count_in   = count_new;
               dropped_in = dropped_ff || store_full;
               if (req_tlast) begin
                  push0_val = '{lo: '0, hi: IDX_W'(count_new - COUNT_W'(1))};
                  if (count_new > COUNT_W'(1)) begin
                     push0_en = 1'b1;
                     sp_in    = sp_ff + SP_W'(1);
                  end
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            ram_raddr = top_range.lo;
            lo_in     = top_range.lo;
            hi_in     = top_range.hi;
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               sp_in    = top_idx;
               state_in = ST_PIVOT;
            end
         end
         ST_PIVOT: begin
            pivot_in  = ram_rdata;
            i_in      = lo_ff + IDX_W'(1);
            j_in      = COUNT_W'(hi_ff) + COUNT_W'(1);
            ram_raddr = lo_ff + IDX_W'(1);
            state_in  = ST_I_CHK;
         end
         ST_I_RD: begin
            ram_raddr = i_ff;
            state_in  = ST_I_CHK;
         end
         ST_I_CHK: begin
            if ((i_ff < hi_ff) && cmp_lt) begin
               i_in      = i_ff + IDX_W'(1);
               ram_raddr = i_ff + IDX_W'(1);
            end else begin
               vi_in     = ram_rdata;
               j_in      = j_dec;
               ram_raddr = j_dec[IDX_W-1:0];
               state_in  = ST_J_CHK;
            end
         end
         ST_J_CHK: begin
            if ((j_ff > COUNT_W'(lo_ff)) && cmp_lt) begin
               j_in      = j_dec;
               ram_raddr = j_dec[IDX_W-1:0];
            end else begin
               vj_in = ram_rdata;
               if (COUNT_W'(i_ff) >= j_ff) begin
                  state_in = ST_FIN1;
               end else begin
                  state_in = ST_SWAP1;
               end
            end
         end
         ST_SWAP1: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = vj_ff;
            state_in  = ST_SWAP2;
         end
         ST_SWAP2: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff[IDX_W-1:0];
            ram_wdata = vi_ff;
            i_in      = i_ff + IDX_W'(1);
            state_in  = ST_I_RD;
         end
         ST_FIN1: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = vj_ff;
            state_in  = ST_FIN2;
         end
         ST_FIN2: begin
            ram_we    = 1'b1;
            ram_waddr = p_idx;
            ram_wdata = pivot_ff;
            // larger part below, smaller part on top
            priority if (left_larger) begin
               push0_en  = left_ok || right_ok;
               push0_val = left_ok ? left_range : right_range;
               push1_en  = left_ok && right_ok;
               push1_val = right_range;
            end else begin
               push0_en  = left_ok || right_ok;
               push0_val = right_ok ? right_range : left_range;
               push1_en  = left_ok && right_ok;
               push1_val = left_range;
            end
            sp_in    = sp_ff + SP_W'(push0_en) + SP_W'(push1_en);
            state_in = ST_POP;
         end
         ST_OUT_RD: begin
            ram_raddr = k_ff;
            state_in  = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            ram_raddr = k_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load    = 1'b1;
               rsp_data_in = ram_rdata;
               rsp_ovf_in  = dropped_ff;
               rsp_last_in = (COUNT_W'(k_ff) + COUNT_W'(1) == count_ff);
               if (rsp_last_in) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  k_in       = '0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         sp_ff        <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         sp_ff        <= sp_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      pivot_ff    <= pivot_in;
      vi_ff       <= vi_in;
      vj_ff       <= vj_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (push0_en) begin
         stack_ff[push0_slot] <= push0_val;
      end
      if (push1_en) begin
         stack_ff[push1_slot] <= push1_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   `QS_ASSERT(a_stack_bound, (sp_ff <= SP_W'(STACK_DEPTH)), "range stack overrun")
   `QS_ASSERT(a_scan_range, (state_ff == ST_I_CHK) |-> (i_ff > lo_ff && i_ff <= hi_ff), "left scan left its range")
   `QS_ASSERT(a_pivot_range, (state_ff == ST_FIN1) |-> (j_ff >= COUNT_W'(lo_ff) && j_ff <= COUNT_W'(hi_ff)), "pivot slot outside range")
   `QS_ASSERT_NEXT(a_run_done, state_ff == ST_OUT_WAIT && rsp_load && rsp_last_in, state_ff == ST_LOAD && count_ff == '0 && sp_ff == '0, "run not closed after final word")

endmodule

// File: bench/quicksort_sorter_tb.sv
// Self-checking bench for quicksort_sorter: loads signed sets, checks the sorted stream,
// last marker and overflow flag against a sort-based predictor. Uses qsort_pkg.
`timescale 1ns / 1ps

module quicksort_sorter_tb;
   import qsort_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TARGET_WORDS   = 260;
   localparam int TAIL_CYCLES    = 60;
   localparam int N_DIRECTED     = 21;

   typedef logic signed [DATA_W-1:0] sval_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
      logic              overflow;
   } sorted_word_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
      logic              single;   // one-word set, result typed in
   } load_row_type;

   // directed sets: extremes, one-word sets, duplicates, sorted and reversed input
   load_row_type load_table [N_DIRECTED] = '{
      '{32'h8000_0000, 1'b1, 1'b1},
      '{32'h7FFF_FFFF, 1'b1, 1'b1},
      '{32'h0000_0000, 1'b1, 1'b1},
      '{32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b0, 1'b0},
      '{32'h0000_0005, 1'b1, 1'b0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0},
      '{32'h0000_0003, 1'b0, 1'b0},
      '{32'h0000_0002, 1'b0, 1'b0},
      '{32'hFFFF_FFF0, 1'b1, 1'b0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // value[31:0]
   logic              req_tlast = 1'b0; // is_last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // sorted_value[31:0]
   logic              rsp_tlast;        // last_out
   logic              rsp_tuser;        // overflow

   sorted_word_type due_sorted[$];
   sval_type        set_values[$];
   bit              set_dropped = 1'b0;

   int send_idle_pct  = 25;
   int sink_stall_pct = 81;
   int mismatches     = 0;
   int words_sent     = 0;
   int results_seen   = 0;
   int sets_closed    = 0;
   int overflow_sets  = 0;
   int stalled_cycles = 0;

   quicksort_sorter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // store an accepted word; on the closing word sort the set and queue its results
   function automatic void sort_loaded_set(sval_type value, bit last, bit single);
      int              i;
      int              j;
      sval_type        key;
      sorted_word_type w;
      if (set_values.size() < MAX_ITEMS) begin
         set_values.push_back(value);
      end else begin
         set_dropped = 1'b1;
      end
      if (!last) return;
      for (i = 1; i < set_values.size(); i++) begin
         key = set_values[i];
         j = i - 1;
         while (j >= 0 && set_values[j] > key) begin
            set_values[j + 1] = set_values[j];
            j--;
         end
         set_values[j + 1] = key;
      end
      if (single) begin
         w = '{value, 1'b1, 1'b0};
         due_sorted.push_back(w);
      end else begin
         for (i = 0; i < set_values.size(); i++) begin
            w = '{set_values[i], i == set_values.size() - 1, set_dropped};
            due_sorted.push_back(w);
         end
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      set_values.delete();
      set_dropped = 1'b0;
   endfunction

   task automatic send_word(sval_type value, bit last, bit single);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      sort_loaded_set(value, last, single);
   endtask

   function automatic sval_type pick_value(int mode, int k, sval_type base);
      case (mode)
         0: return sval_type'($urandom);
         1: return sval_type'($urandom_range(8)) - 4;
         2: return base + sval_type'(k * 3);
         3: return base - sval_type'(k * 3);
         default: begin
            case ($urandom_range(3))
               0: return sval_type'(32'h8000_0000);
               1: return sval_type'(32'h7FFF_FFFF);
               2: return sval_type'($urandom_range(2)) - 1;
               default: return sval_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic report_word(string what, sorted_word_type exp_w, sorted_word_type got_w);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected value %h last %b ovf %b, got value %h last %b ovf %b",
                  $realtime, what, exp_w.value, exp_w.last, exp_w.overflow,
                  got_w.value, got_w.last, got_w.overflow);
   endtask

   always @(posedge clock) begin : sink_check
      sorted_word_type got_w;
      sorted_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got_w = '{rsp_tdata, rsp_tlast, rsp_tuser};
         if (due_sorted.size() == 0) begin
            report_word("unexpected word", '0, got_w);
         end else begin
            exp_w = due_sorted.pop_front();
            if (got_w.value !== exp_w.value || got_w.last !== exp_w.last ||
                got_w.overflow !== exp_w.overflow)
               report_word("mismatch", exp_w, got_w);
         end
      end
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d words still due", due_sorted.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int       r;
      int       set_size;
      int       mode;
      int       k;
      int       random_words;
      sval_type base;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++)
         send_word(load_table[k].value, load_table[k].last, load_table[k].single);

      random_words = 0;
      while (words_sent < TARGET_WORDS) begin
         if (random_words >= 160) begin
            send_idle_pct  = 0;
            sink_stall_pct = 0;
         end else if (random_words >= 80) begin
            send_idle_pct  = 81;
            sink_stall_pct = 25;
         end
         r = $urandom_range(99);
         if (r < 55)      set_size = $urandom_range(10, 1);
         else if (r < 75) set_size = $urandom_range(MAX_ITEMS - 1, 11);
         else if (r < 85) set_size = MAX_ITEMS;
         else             set_size = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS + 1);
         mode = $urandom_range(4);
         base = sval_type'($urandom);
         for (k = 0; k < set_size; k++)
            send_word(pick_value(mode, k, base), k == set_size - 1, 1'b0);
         random_words += set_size;
      end
      req_tvalid <= 1'b0;

      while (due_sorted.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Loaded %0d words in %0d sets (%0d with dropped words), %0d sorted words back.",
               words_sent, sets_closed, overflow_sets, results_seen);
      $display("Mismatches: %0d, words still due: %0d.", mismatches, due_sorted.size());
      if (mismatches == 0 && due_sorted.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/qsort_pkg.sv
design/qsort_ram.sv
design/quicksort_sorter.sv
bench/quicksort_sorter_tb.sv
